FILE: sv/qir_pkg.sv
// qir_pkg: shared types and constants for queue_insert_and_rotate.
// Holds the request and result structs and the per-cycle cell command.
// No dependencies.
package qir_pkg;

	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	localparam logic [2:0] OP_ENQ  = 3'd0;
	localparam logic [2:0] OP_DEQ  = 3'd1;
	localparam logic [2:0] OP_INS  = 3'd2;
	localparam logic [2:0] OP_ROTL = 3'd3;
	localparam logic [2:0] OP_ROTR = 3'd4;

	localparam logic [1:0] STAT_DONE   = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_EMPTY  = 2'd2;
	localparam logic [1:0] STAT_ROTATE = 2'd3;

	typedef logic [2:0] cell_cmd_t;
	localparam cell_cmd_t CMD_NOP    = 3'd0;
	localparam cell_cmd_t CMD_WRITE  = 3'd1;
	localparam cell_cmd_t CMD_SHIFT  = 3'd2;
	localparam cell_cmd_t CMD_INSERT = 3'd3;
	localparam cell_cmd_t CMD_ROTATE = 3'd4;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] item_value;
		logic [7:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [31:0] head_value;
		logic [6:0]         entry_count;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		cell_cmd_t          cmd;
		logic [CNT_W-1:0]   target;
		logic [CNT_W-1:0]   last;
		logic signed [31:0] value;
	} cell_ctl_t;

endpackage

FILE: sv/qir_cell.sv
// qir_cell: one queue slot of the cell chain.
// Takes its word from a neighbor, the head cell or the request per command.
// Depends on qir_pkg.
module qir_cell import qir_pkg::*; (
	input  logic                     clk,
	input  logic [CNT_W-1:0]         index,
	input  cell_ctl_t                ctl,
	input  logic signed [31:0]       head_in,
	input  logic signed [31:0]       left,
	input  logic signed [31:0]       right,
	output logic signed [31:0]       data
);

	logic signed [31:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			CMD_WRITE: begin
				if (index == ctl.target) data_q <= ctl.value;
			end
			CMD_SHIFT: begin
				data_q <= right;
			end
			CMD_INSERT: begin
				if (index > ctl.target) data_q <= left;
				else if (index == ctl.target) data_q <= ctl.value;
			end
			CMD_ROTATE: begin
				if (index == ctl.last) data_q <= head_in;
				else if (index < ctl.last) data_q <= right;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

FILE: sv/qir_ctrl.sv
// qir_ctrl: request decode, entry count, rotate step counter and result register.
// Drives one command per cycle to the cell chain.
// Depends on qir_pkg.
module qir_ctrl import qir_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  req_t               req,
	input  logic signed [31:0] head_in,
	output cell_ctl_t          ctl,
	output logic               busy,
	output logic               done,
	output rsp_t               rsp
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_ROT  = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] steps_q;
	logic             done_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic             too_far;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic [CNT_W-1:0] pos_n;
	logic [CNT_W-1:0] nxt_cnt;
	logic [1:0]       nxt_status;
	logic signed [31:0] nxt_head;
	logic             go_rot;
	logic [CNT_W-1:0] rot_steps;

	assign accept  = start && (state_q == S_IDLE);
	assign pos_ext = CMP_W'(req.position);
	assign cnt_ext = CMP_W'(cnt_q);
	assign pos_n   = CNT_W'(req.position);
	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign too_far = (pos_ext >= cnt_ext);

	always_comb begin
		ctl.cmd    = CMD_NOP;
		ctl.target = cnt_q;
		ctl.last   = cnt_q - CNT_W'(1);
		ctl.value  = req.item_value;
		nxt_cnt    = cnt_q;
		nxt_status = STAT_DONE;
		nxt_head   = '0;
		go_rot     = 1'b0;
		rot_steps  = '0;
		if (state_q == S_ROT) begin
			ctl.cmd = CMD_ROTATE;
		end else begin
			unique case (req.operation)
				OP_ENQ: begin
					if (full) nxt_status = STAT_FULL;
					else begin
						ctl.cmd = CMD_WRITE;
						nxt_cnt = cnt_q + CNT_W'(1);
					end
				end
				OP_DEQ: begin
					if (empty) nxt_status = STAT_EMPTY;
					else begin
						ctl.cmd  = CMD_SHIFT;
						nxt_head = head_in;
						nxt_cnt  = cnt_q - CNT_W'(1);
					end
				end
				OP_INS: begin
					if (full) nxt_status = STAT_FULL;
					else begin
						ctl.cmd    = CMD_INSERT;
						ctl.target = too_far ? cnt_q : pos_n;
						nxt_cnt    = cnt_q + CNT_W'(1);
					end
				end
				OP_ROTL: begin
					if (too_far) nxt_status = STAT_ROTATE;
					else begin
						rot_steps = pos_n;
						go_rot    = (pos_n != '0);
					end
				end
				OP_ROTR: begin
					if (too_far) nxt_status = STAT_ROTATE;
					else begin
						rot_steps = cnt_q - pos_n;
						go_rot    = (pos_n != '0);
					end
				end
				default: begin
					nxt_status = STAT_DONE;
				end
			endcase
			if (!accept) ctl.cmd = CMD_NOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			steps_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (state_q == S_ROT) begin
				steps_q <= steps_q - CNT_W'(1);
				if (steps_q == CNT_W'(1)) begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
			end else if (accept) begin
				cnt_q <= nxt_cnt;
				if (go_rot) begin
					state_q <= S_ROT;
					steps_q <= rot_steps;
				end else begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.head_value  <= nxt_head;
			rsp_q.entry_count <= 7'(nxt_cnt);
			rsp_q.status      <= nxt_status;
		end
	end

	assign busy = (state_q == S_ROT);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe while rotating");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_steps_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROT |-> steps_q != '0)
		else $error("rotate with no steps left");

	a_rot_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROT |=> $stable(cnt_q))
		else $error("count changed during rotate");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.operation == OP_ENQ && !full |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("enqueue did not grow count");

endmodule

FILE: sv/queue_insert_and_rotate.sv
// queue_insert_and_rotate: bounded queue of signed words with insert and rotate.
// Top level; instantiates qir_ctrl and a chain of qir_cell. Depends on qir_pkg.
//
// Usage:
//   Request channel: drive req and raise start; the request is taken at a
//   rising edge where start is high and busy is low.
//   Result channel: one result per request, on rsp for exactly one cycle
//   with done high. The receiver cannot stall it and must take it then.
// Completion:
//   Enqueue, dequeue, insert, refused requests and rotates that move nothing
//   finish without a busy phase: done rises the cycle after the request, and a new
//   request can be taken in that same cycle (busy stays low).
//   A rotate left by n moves the chain one slot per cycle, n slots in all; a
//   rotate right by n moves it count - n slots. busy is high while it moves
//   and done follows the last step; no new request is taken until busy falls.
//   The step counter in qir_ctrl that drives the cell chain ends the rotate.
// Reset:
//   arst_n clears the count and the control state; slot contents are not
//   cleared and are only read after being written.
module queue_insert_and_rotate import qir_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	cell_ctl_t          ctl;
	logic signed [31:0] slot [DEPTH];

	qir_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.head_in (slot[0]),
		.ctl     (ctl),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] left;
		logic signed [31:0] right;

		if (i == 0) begin : g_first
			assign left = slot[i];
		end else begin : g_mid_l
			assign left = slot[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right = slot[i];
		end else begin : g_mid_r
			assign right = slot[i+1];
		end

		qir_cell u_cell (
			.clk     (clk),
			.index   (CNT_W'(i)),
			.ctl     (ctl),
			.head_in (slot[0]),
			.left    (left),
			.right   (right),
			.data    (slot[i])
		);
	end

endmodule

FILE: tb/sv/queue_insert_and_rotate_tb.sv
// Testbench for queue_insert_and_rotate: directed corner requests, then biased random
// requests, checked one for one against a scoreboard that mirrors the queue contents.
// Depends on qir_pkg and the queue_insert_and_rotate RTL.
module queue_insert_and_rotate_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qir_pkg::*;

	localparam int N_RANDOM = 1950;
	localparam int LIMIT_NS = 2_000_000;
	localparam logic [2:0] OP_RSVD_LO = 3'd5;
	localparam logic [2:0] OP_RSVD_HI = 3'd7;

	class qir_scoreboard;
		logic signed [31:0] held_words[$];
		rsp_t pending_results[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function int held_count();
			return held_words.size();
		endfunction

		function int waiting();
			return pending_results.size();
		endfunction

		function void rotate_left(int n);
			for (int i = 0; i < n; i++) begin
				held_words.push_back(held_words.pop_front());
			end
		endfunction

		function void note_request(req_t r);
			rsp_t want;
			int cnt;
			int at;
			cnt = held_words.size();
			want = '0;
			want.status = STAT_DONE;
			case (r.operation)
			OP_ENQ: begin
				if (cnt >= DEPTH) want.status = STAT_FULL;
				else held_words.push_back(r.item_value);
			end
			OP_DEQ: begin
				if (cnt == 0) want.status = STAT_EMPTY;
				else want.head_value = held_words.pop_front();
			end
			OP_INS: begin
				if (cnt >= DEPTH) begin
					want.status = STAT_FULL;
				end else begin
					at = (int'(r.position) < cnt) ? int'(r.position) : cnt;
					held_words.insert(at, r.item_value);
				end
			end
			OP_ROTL: begin
				if (int'(r.position) >= cnt) want.status = STAT_ROTATE;
				else rotate_left(int'(r.position));
			end
			OP_ROTR: begin
				if (int'(r.position) >= cnt) want.status = STAT_ROTATE;
				else if (r.position != 0) rotate_left(cnt - int'(r.position));
			end
			default: ;
			endcase
			want.entry_count = 7'(held_words.size());
			pending_results.push_back(want);
		endfunction

		task report(string msg);
			$display("%0t ERROR: %s", $time, msg);
			errors++;
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing pending: %p", got));
			end else begin
				want = pending_results.pop_front();
				if (got.head_value !== want.head_value)
					report($sformatf("head_value got %0d want %0d",
						got.head_value, want.head_value));
				if (got.entry_count !== want.entry_count)
					report($sformatf("entry_count got %0d want %0d",
						got.entry_count, want.entry_count));
				if (got.status !== want.status)
					report($sformatf("status got %0d want %0d", got.status, want.status));
			end
		endtask

		task drain_check();
			if (pending_results.size() != 0)
				report($sformatf("%0d results never arrived", pending_results.size()));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	qir_scoreboard sb;
	int sender_idle_pct;

	queue_insert_and_rotate u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(rsp);
			if (start && !busy) sb.note_request(req);
		end
	end

	// Called at a rising edge; returns at the edge where the request is taken.
	// busy is sampled at the falling edge, where it is settled.
	task automatic drive_request(req_t r);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic send(logic [2:0] op, logic signed [31:0] val, logic [7:0] pos);
		req_t r;
		r.operation = op;
		r.item_value = val;
		r.position = pos;
		drive_request(r);
	endtask

	function automatic logic [7:0] pick_position(int cnt);
		int roll;
		roll = $urandom_range(99);
		if (roll < 10) return 8'd0;
		if (roll < 22) return 8'($urandom_range(255));
		return 8'($urandom_range(cnt));
	endfunction

	function automatic int pick_target();
		case ($urandom_range(3))
		0: return $urandom_range(8);
		1: return $urandom_range(40, 9);
		default: return DEPTH;
		endcase
	endfunction

	// Steers the fill level toward target so that empty and full stores both get reached.
	function automatic req_t random_request(int target);
		req_t r;
		int cnt;
		int roll;
		cnt = sb.held_count();
		roll = $urandom_range(99);
		r.item_value = $urandom;
		r.position = pick_position(cnt);
		if (roll < 4)
			r.operation = 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
		else if (roll < 44)
			r.operation = (cnt < target) ? ($urandom_range(1) ? OP_ENQ : OP_INS) : OP_DEQ;
		else if (roll < 54)
			r.operation = OP_DEQ;
		else if (roll < 64)
			r.operation = $urandom_range(1) ? OP_ENQ : OP_INS;
		else if (roll < 82)
			r.operation = OP_ROTL;
		else
			r.operation = OP_ROTR;
		return r;
	endfunction

	initial begin
		int fill_target;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		sender_idle_pct = 33;
		fill_target = 0;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_DEQ, 32'sd0, 8'd0);
		send(OP_ROTL, 32'sd0, 8'd0);
		send(OP_ROTR, 32'sd0, 8'd0);
		send(OP_ENQ, 32'sh7fffffff, 8'hff);
		send(OP_ENQ, 32'sh80000000, 8'd0);
		send(OP_ENQ, -32'sd1, 8'd0);
		send(OP_ENQ, 32'sd0, 8'd0);
		send(OP_INS, 32'sh55555555, 8'd0);
		send(OP_INS, 32'shaaaaaaaa, 8'hff);
		send(OP_INS, 32'sh12345678, 8'd3);
		send(OP_ROTL, 32'sd0, 8'd0);
		send(OP_ROTR, 32'sd0, 8'd0);
		send(OP_ROTL, 32'sd0, 8'd1);
		send(OP_ROTR, 32'sd0, 8'd1);
		send(OP_ROTL, 32'sd0, 8'd6);
		send(OP_ROTR, 32'sd0, 8'd6);
		send(OP_ROTL, 32'sd0, 8'd7);
		send(OP_ROTR, 32'sd0, 8'hff);
		for (int c = OP_RSVD_LO; c <= OP_RSVD_HI; c++) begin
			send(3'(c), -32'sd1, 8'hff);
		end
		send(OP_DEQ, 32'sd0, 8'd0);
		send(OP_DEQ, 32'sd0, 8'd0);

		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM / 3) sender_idle_pct = 59;
			if (k == 2 * N_RANDOM / 3) sender_idle_pct = 0;
			if (k % 100 == 0) fill_target = pick_target();
			drive_request(random_request(fill_target));
		end
		start <= 1'b0;

		while (sb.waiting() != 0) @(posedge clk);
		repeat (2 * DEPTH) @(posedge clk);
		sb.drain_check();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("%0t ERROR: timeout", $time);
		$display("Test completed with failures");
		$finish;
	end

endmodule
